@@ rtl/tets_pkg.sv @@
// Shared types, constants and a helper function for the timed event table sequencer.
`timescale 1ns / 1ps
package tets_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int TIME_BITS   = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Request kind codes.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_PPS   = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_START = 2'd3;

   // Action codes.
   localparam logic [3:0] ACT_RESTART     = 4'd0;
   localparam logic [3:0] ACT_CHANNEL     = 4'd5;
   localparam logic [3:0] ACT_LISTEN_SEND = 4'd7;
   localparam logic [3:0] ACT_LAST        = 4'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  entry_index;
      logic [15:0] entry_time;
      logic [3:0]  entry_action;
      logic [15:0] entry_data;
   } req_type;

   typedef struct packed {
      logic [4:0]  event_index;
      logic [3:0]  event_action;
      logic [15:0] event_data;
      logic [15:0] next_wait;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_PPS   = 2'd2,
      OP_TICK  = 2'd3
   } cmd_op_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [3:0]           action;
      logic [15:0]          data;
   } entry_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [IDX_BITS-1:0] idx;
      entry_type           entry;
   } cmd_type;

   // Ticks from now to target, modulo the time width; a zero wait counts as one tick.
   function automatic logic [TIME_BITS-1:0] wait_of(input logic [TIME_BITS-1:0] target,
                                                    input logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] diff;
      diff = target - now;
      return (diff == '0) ? TIME_BITS'(1) : diff;
   endfunction

endpackage

@@ rtl/tets_front.sv @@
// Front end: accepts requests and turns them into sequencer commands.
`timescale 1ns / 1ps
module tets_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  tets_pkg::req_type  req_payload,
   output logic               push,
   output tets_pkg::cmd_type  push_cmd,
   input  logic               queue_full
);

   logic in_range;

   assign req_ready = !queue_full;
   assign in_range  = int'(req_payload.entry_index) < tets_pkg::TABLE_DEPTH;

   always_comb begin
      push_cmd.idx            = tets_pkg::IDX_BITS'(req_payload.entry_index);
      push_cmd.entry.time_val = tets_pkg::TIME_BITS'(req_payload.entry_time);
      push_cmd.entry.action   = req_payload.entry_action;
      push_cmd.entry.data     = req_payload.entry_data;
      unique case (req_payload.kind)
         tets_pkg::KIND_TICK:  push_cmd.op = tets_pkg::OP_TICK;
         tets_pkg::KIND_PPS:   push_cmd.op = tets_pkg::OP_PPS;
         tets_pkg::KIND_WRITE: push_cmd.op = tets_pkg::OP_WRITE;
         default:              push_cmd.op = tets_pkg::OP_START;
      endcase
   end

   // Writes beyond the table are taken and dropped here.
   assign push = req_valid && req_ready &&
                 !((req_payload.kind == tets_pkg::KIND_WRITE) && !in_range);

endmodule

@@ rtl/tets_queue.sv @@
// Short command queue between the front end and the sequencer.
`timescale 1ns / 1ps
module tets_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tets_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output tets_pkg::cmd_type pop_cmd
);

   tets_pkg::cmd_type                  slot_ff [tets_pkg::QUEUE_DEPTH];
   logic [tets_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tets_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tets_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                               do_push, do_pop;

   assign full      = (count_ff == tets_pkg::QCNT_BITS'(tets_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/tets_back.sv @@
// Back end: event table memory, countdown sequencer and result register.
`timescale 1ns / 1ps
module tets_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tets_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tets_pkg::rsp_type rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD0 = 4'b0010,
      ST_CUR   = 4'b0100,
      ST_NEXT  = 4'b1000
   } state_type;

   localparam logic [tets_pkg::IDX_BITS-1:0] LastIdx =
      tets_pkg::IDX_BITS'(tets_pkg::TABLE_DEPTH - 1);

   tets_pkg::entry_type                mem [tets_pkg::TABLE_DEPTH];
   tets_pkg::entry_type                rd_data_ff;
   logic                               rd_en;
   logic [tets_pkg::IDX_BITS-1:0]      rd_addr;
   logic                               wr_en;

   state_type                          state_ff, state_in;
   logic                               running_ff, running_in;
   logic                               synced_ff, synced_in;
   logic [tets_pkg::IDX_BITS-1:0]      awaited_ff, awaited_in;
   logic [tets_pkg::TIME_BITS-1:0]     ticks_ff, ticks_in;
   logic [tets_pkg::IDX_BITS-1:0]      cur_idx_ff, cur_idx_in;
   logic [3:0]                         cur_act_ff, cur_act_in;
   logic [15:0]                        cur_data_ff, cur_data_in;
   logic [tets_pkg::TIME_BITS-1:0]     now_ff, now_in;
   logic                               out_valid_ff, out_valid_in;
   tets_pkg::rsp_type                  out_ff, out_in;

   logic                               slot_free;
   logic                               emit;
   logic [tets_pkg::TIME_BITS-1:0]     next_wait;

   assign slot_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign emit        = (cur_act_ff != tets_pkg::ACT_RESTART) &&
                        (cur_act_ff <= tets_pkg::ACT_LAST);
   assign next_wait   = tets_pkg::wait_of(rd_data_ff.time_val, now_ff);

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      synced_in    = synced_ff;
      awaited_in   = awaited_ff;
      ticks_in     = ticks_ff;
      cur_idx_in   = cur_idx_ff;
      cur_act_in   = cur_act_ff;
      cur_data_in  = cur_data_ff;
      now_in       = now_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  tets_pkg::OP_WRITE: begin
                     wr_en = 1'b1;
                  end
                  tets_pkg::OP_START: begin
                     running_in = 1'b1;
                     awaited_in = '0;
                     rd_en      = 1'b1;
                     state_in   = ST_LOAD0;
                  end
                  tets_pkg::OP_PPS: begin
                     if (running_ff && !synced_ff) begin
                        synced_in  = 1'b1;
                        awaited_in = '0;
                        rd_en      = 1'b1;
                        state_in   = ST_LOAD0;
                     end
                  end
                  default: begin
                     if (running_ff) begin
                        if (ticks_ff > tets_pkg::TIME_BITS'(1)) begin
                           ticks_in = ticks_ff - 1'b1;
                        end else begin
                           rd_en      = 1'b1;
                           rd_addr    = awaited_ff;
                           cur_idx_in = awaited_ff;
                           state_in   = ST_CUR;
                        end
                     end
                  end
               endcase
            end
         end
         ST_LOAD0: begin
            ticks_in = tets_pkg::wait_of(rd_data_ff.time_val, '0);
            state_in = ST_IDLE;
         end
         ST_CUR: begin
            cur_act_in  = rd_data_ff.action;
            cur_data_in = rd_data_ff.data;
            rd_en       = 1'b1;
            if (rd_data_ff.action == tets_pkg::ACT_RESTART) begin
               now_in  = '0;
               rd_addr = '0;
            end else begin
               now_in  = rd_data_ff.time_val;
               rd_addr = (cur_idx_ff == LastIdx) ? '0 : cur_idx_ff + 1'b1;
            end
            awaited_in = rd_addr;
            state_in   = ST_NEXT;
         end
         default: begin
            // Wait here while a finished result still occupies the output register.
            if (!emit || slot_free) begin
               ticks_in = next_wait;
               state_in = ST_IDLE;
               if (emit) begin
                  out_valid_in       = 1'b1;
                  out_in.event_index = 5'(cur_idx_ff);
                  out_in.event_action = cur_act_ff;
                  out_in.event_data  = ((cur_act_ff == tets_pkg::ACT_CHANNEL) ||
                                        (cur_act_ff == tets_pkg::ACT_LISTEN_SEND)) ?
                                       cur_data_ff : 16'd0;
                  out_in.next_wait   = 16'(next_wait);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         synced_ff    <= 1'b0;
         awaited_ff   <= '0;
         ticks_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         synced_ff    <= synced_in;
         awaited_ff   <= awaited_in;
         ticks_ff     <= ticks_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      cur_act_ff  <= cur_act_in;
      cur_data_ff <= cur_data_in;
      now_ff      <= now_in;
      out_ff      <= out_in;
   end

   // Event table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cmd.idx] <= cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/timed_event_table_sequencer_top.sv @@
// Top level of the timed event table sequencer: front end, command queue and back end.
`timescale 1ns / 1ps
// With an empty queue and a free output register, a firing tick's request passes through
// the queue, the current-entry read, the next-entry read and the result register.
// Throughput: writes, ignored pulses and non-firing ticks retire one per cycle while the back
// end is idle; a firing tick holds the back end for two dependent table reads and the result load,
// a start or resync for one table read. The four-entry queue absorbs the difference.
// Reset: synchronous, active high; clears the queue, control state and result valid flag,
// not the held entry or result data. The event table stays undefined until written.
module timed_event_table_sequencer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tets_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tets_pkg::rsp_type rsp_payload
);

   // Commands flow from the front end through the queue into the back end.
   logic              push;
   logic              queue_full;
   logic              pop;
   logic              pop_valid;
   tets_pkg::cmd_type push_cmd;
   tets_pkg::cmd_type pop_cmd;

   // The front end decodes each request kind and drops table writes whose
   // index lies beyond the table.
   tets_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   // The queue absorbs request bursts while the back end performs table reads.
   tets_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   // The back end owns the table, the countdown and the output register, so it
   // can take new commands while a result waits for the consumer.
   tets_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
